// ===== sv/uartirq_pkg.sv =====
package uartirq_pkg;

    // Operation codes carried by one input beat.
    localparam logic [1:0] OP_LINE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register selects.
    localparam logic [1:0] REG_DATA   = 2'd0;
    localparam logic [1:0] REG_STATUS = 2'd1;
    localparam logic [1:0] REG_CTRL   = 2'd2;
    localparam logic [1:0] REG_GLOBAL = 2'd3;

    // Bit positions in status A and control B.
    localparam int BIT_RXC  = 7;
    localparam int BIT_TXC  = 6;
    localparam int BIT_UDRE = 5;
    localparam int BIT_RXEN = 4;
    localparam int BIT_GIE  = 7;

    localparam logic [7:0] KEEP_MASK    = 8'hE3;
    localparam logic [7:0] ERR_MASK     = 8'h1C;
    localparam logic [7:0] STATUS_RESET = 8'h20;

    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq_receive;
        logic       irq_transmit;
        logic       irq_empty;
    } t_result;

endpackage

// ===== sv/uart_rx_fifo_irq_flags_top.sv =====
// UART register block with a two-deep receive store (data register plus one
// hold byte) and the receive-complete, transmit-complete and data-empty flags
// with their interrupt requests. Every input beat is a line byte, a register
// read or a register write, and every beat produces exactly one result beat
// carrying the read data, the transmitted byte and the interrupt requests
// raised by that beat. The block accepts one beat per clock cycle unless
// o_stall is high; each result is registered in the output stage below.
// The register state is updated by a single level of combinational logic at
// the accepting edge, and the result lands in a two-entry output stage (an
// output register and a skid register), so input is stalled only when both
// entries hold results the downstream side has not yet taken.
module uart_rx_fifo_irq_flags_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_opcode,
    input  logic [1:0] i_reg_select,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_read_data,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_irq_receive,
    output logic       o_irq_transmit,
    output logic       o_irq_empty
);
    import uartirq_pkg::*;

    // Architectural register state.
    logic [7:0] r_status, n_status;
    logic [7:0] r_ctrl, n_ctrl;
    logic [7:0] r_rx_data, n_rx_data;
    logic [7:0] r_rx_hold, n_rx_hold;
    logic [1:0] r_rx_count, n_rx_count;
    logic       r_gie, n_gie;

    // Output stage: the register that drives the ports and a skid entry
    // behind it that catches a beat taken while the output is stalled.
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    t_result n_result;

    logic       accept;
    logic       out_free;
    logic [7:0] rising;
    logic [7:0] pend;

    assign o_stall  = r_skid_valid;
    assign accept   = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_status   = r_status;
        n_ctrl     = r_ctrl;
        n_rx_data  = r_rx_data;
        n_rx_hold  = r_rx_hold;
        n_rx_count = r_rx_count;
        n_gie      = r_gie;
        n_result   = '0;
        rising     = i_data_byte & ~r_ctrl;
        pend       = r_ctrl & r_status;
        unique case (i_opcode)
            OP_LINE: begin
                // Line bytes are taken only while receive is enabled; a
                // byte arriving with both entries full is dropped.
                if (r_ctrl[BIT_RXEN]) begin
                    if (r_rx_count == CNT_EMPTY) begin
                        n_rx_data             = i_data_byte;
                        n_rx_count            = CNT_ONE;
                        n_status[BIT_RXC]     = 1'b1;
                        n_result.irq_receive  = r_ctrl[BIT_RXC] && r_gie;
                    end else if (r_rx_count == CNT_ONE) begin
                        n_rx_hold  = i_data_byte;
                        n_rx_count = CNT_TWO;
                    end
                end
            end
            OP_READ: begin
                unique case (i_reg_select)
                    REG_DATA: begin
                        n_result.read_data = r_rx_data;
                        if (r_rx_count[1]) begin
                            // Pop the hold byte; receive complete stays set.
                            n_rx_data            = r_rx_hold;
                            n_status             = r_status & KEEP_MASK;
                            n_result.irq_receive = r_ctrl[BIT_RXC] && r_gie;
                            n_rx_count           = CNT_ONE;
                        end else if (r_rx_count == CNT_ONE) begin
                            n_status[BIT_RXC] = 1'b0;
                            n_rx_count        = CNT_EMPTY;
                        end
                    end
                    REG_STATUS: n_result.read_data = r_status;
                    REG_CTRL:   n_result.read_data = r_ctrl;
                    default:    n_result.read_data = {r_gie, 7'd0};
                endcase
            end
            OP_WRITE: begin
                unique case (i_reg_select)
                    REG_DATA: begin
                        n_result.tx_valid = 1'b1;
                        n_result.tx_byte  = i_data_byte;
                        if (r_ctrl[BIT_TXC] && r_gie) begin
                            n_result.irq_transmit = 1'b1;
                        end else begin
                            n_status[BIT_TXC] = 1'b1;
                        end
                        n_result.irq_empty = r_ctrl[BIT_UDRE] && r_gie;
                    end
                    REG_STATUS: begin
                        if (i_data_byte[BIT_TXC]) begin
                            n_status[BIT_TXC] = 1'b0;
                        end
                    end
                    REG_CTRL: begin
                        if (!i_data_byte[BIT_RXEN]) begin
                            n_rx_count        = CNT_EMPTY;
                            n_status[BIT_RXC] = 1'b0;
                        end
                        // Only the first newly enabled pending source fires,
                        // judged on the flags after any receive flush.
                        if (rising[BIT_RXC] && n_status[BIT_RXC]) begin
                            n_result.irq_receive = r_gie;
                        end else if (rising[BIT_TXC] && n_status[BIT_TXC]) begin
                            if (r_gie) begin
                                n_result.irq_transmit = 1'b1;
                                n_status[BIT_TXC]     = 1'b0;
                            end
                        end else if (rising[BIT_UDRE] && n_status[BIT_UDRE]) begin
                            n_result.irq_empty = r_gie;
                        end
                        n_ctrl = i_data_byte;
                    end
                    default: begin
                        if (i_data_byte[BIT_GIE] && !r_gie) begin
                            if (pend[BIT_RXC]) begin
                                n_result.irq_receive = 1'b1;
                            end else if (pend[BIT_TXC]) begin
                                n_result.irq_transmit = 1'b1;
                                n_status[BIT_TXC]     = 1'b0;
                            end else if (pend[BIT_UDRE]) begin
                                n_result.irq_empty = 1'b1;
                            end
                        end
                        n_gie = i_data_byte[BIT_GIE];
                    end
                endcase
            end
            default: begin
                // Unused opcode: no state change and an all-zero result.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status   <= STATUS_RESET;
            r_ctrl     <= '0;
            r_rx_data  <= '0;
            r_rx_count <= CNT_EMPTY;
            r_gie      <= 1'b0;
        end else if (accept) begin
            r_status   <= n_status;
            r_ctrl     <= n_ctrl;
            r_rx_data  <= n_rx_data;
            r_rx_count <= n_rx_count;
            r_gie      <= n_gie;
        end
    end

    // The hold byte is read only after a line byte has filled it.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rx_hold <= n_rx_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= n_result;
            end
        end else if (accept) begin
            r_skid <= n_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_read_data    = r_out.read_data;
    assign o_tx_valid     = r_out.tx_valid;
    assign o_tx_byte      = r_out.tx_byte;
    assign o_irq_receive  = r_out.irq_receive;
    assign o_irq_transmit = r_out.irq_transmit;
    assign o_irq_empty    = r_out.irq_empty;

    // The skid entry is only ever filled behind an occupied output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // Receive complete tracks a non-empty receive store.
    a_rxc_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_status[BIT_RXC] == (r_rx_count != CNT_EMPTY))
        else $error("receive-complete flag disagrees with store count");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_count != 2'd3)
        else $error("receive store count out of range");

    a_errors_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status & ERR_MASK) == 8'd0)
        else $error("error bits set in status");

    // A receive request never shares a beat with another request; a data
    // write may raise transmit and data-empty together.
    a_rx_irq_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.irq_receive) |-> !(r_out.irq_transmit || r_out.irq_empty))
        else $error("receive request raised together with another request");

endmodule

// ===== tb/sv/uart_rx_fifo_irq_flags_top_tb.sv =====
`timescale 1ns / 1ps

module uart_rx_fifo_irq_flags_top_tb;

    import uartirq_pkg::*;

    // Opcode 3 is not used by the block; it must produce an all-zero beat.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 2000;
    // Items at the end of the run that are sent with no idling on either side.
    localparam int QUIET_TAIL = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    // Scoreboard: a bit-exact model of the UART register side plus the queue
    // of result beats it still owes the checker.
    class uart_flag_scoreboard;
        logic [7:0] status_q;
        logic [7:0] ctrl_q;
        logic [7:0] rx_data_q;
        logic [7:0] rx_hold_q;
        logic [1:0] rx_cnt_q;
        logic       gie_q;
        t_result    owed[$];
        int         errors;

        function new();
            status_q  = STATUS_RESET;
            ctrl_q    = '0;
            rx_data_q = '0;
            rx_hold_q = '0;
            rx_cnt_q  = CNT_EMPTY;
            gie_q     = 1'b0;
            errors    = 0;
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        // Applies one accepted input beat to the model and queues its result.
        function void note_beat(logic [1:0] op, logic [1:0] sel, logic [7:0] v);
            t_result    res;
            logic [7:0] rising;
            logic [7:0] pend;
            res = '0;
            case (op)
                OP_LINE: begin
                    if (ctrl_q[BIT_RXEN]) begin
                        if (rx_cnt_q == CNT_EMPTY) begin
                            rx_data_q = v;
                            rx_cnt_q = CNT_ONE;
                            status_q[BIT_RXC] = 1'b1;
                            if (ctrl_q[BIT_RXC] && gie_q)
                                res.irq_receive = 1'b1;
                        end else if (rx_cnt_q == CNT_ONE) begin
                            rx_hold_q = v;
                            rx_cnt_q = CNT_TWO;
                        end
                    end
                end
                OP_READ: begin
                    case (sel)
                        REG_DATA: begin
                            res.read_data = rx_data_q;
                            if (rx_cnt_q >= CNT_TWO) begin
                                rx_data_q = rx_hold_q;
                                status_q = status_q & KEEP_MASK;
                                if (ctrl_q[BIT_RXC] && gie_q)
                                    res.irq_receive = 1'b1;
                                rx_cnt_q = CNT_ONE;
                            end else if (rx_cnt_q == CNT_ONE) begin
                                status_q[BIT_RXC] = 1'b0;
                                rx_cnt_q = CNT_EMPTY;
                            end
                        end
                        REG_STATUS: res.read_data = status_q;
                        REG_CTRL:   res.read_data = ctrl_q;
                        default:    res.read_data = {gie_q, 7'd0};
                    endcase
                end
                OP_WRITE: begin
                    case (sel)
                        REG_DATA: begin
                            res.tx_valid = 1'b1;
                            res.tx_byte = v;
                            if (ctrl_q[BIT_TXC] && gie_q)
                                res.irq_transmit = 1'b1;
                            else
                                status_q[BIT_TXC] = 1'b1;
                            if (ctrl_q[BIT_UDRE] && gie_q)
                                res.irq_empty = 1'b1;
                        end
                        REG_STATUS: begin
                            if (v[BIT_TXC])
                                status_q[BIT_TXC] = 1'b0;
                        end
                        REG_CTRL: begin
                            rising = v & ~ctrl_q;
                            if (!v[BIT_RXEN]) begin
                                rx_cnt_q = CNT_EMPTY;
                                status_q[BIT_RXC] = 1'b0;
                            end
                            if (rising[BIT_RXC] && status_q[BIT_RXC]) begin
                                if (gie_q)
                                    res.irq_receive = 1'b1;
                            end else if (rising[BIT_TXC] && status_q[BIT_TXC]) begin
                                if (gie_q) begin
                                    res.irq_transmit = 1'b1;
                                    status_q[BIT_TXC] = 1'b0;
                                end
                            end else if (rising[BIT_UDRE] && status_q[BIT_UDRE]) begin
                                if (gie_q)
                                    res.irq_empty = 1'b1;
                            end
                            ctrl_q = v;
                        end
                        default: begin
                            if (v[BIT_GIE] && !gie_q) begin
                                pend = ctrl_q & status_q;
                                if (pend[BIT_RXC]) begin
                                    res.irq_receive = 1'b1;
                                end else if (pend[BIT_TXC]) begin
                                    res.irq_transmit = 1'b1;
                                    status_q[BIT_TXC] = 1'b0;
                                end else if (pend[BIT_UDRE]) begin
                                    res.irq_empty = 1'b1;
                                end
                            end
                            gie_q = v[BIT_GIE];
                        end
                    endcase
                end
                default: ;
            endcase
            owed.push_back(res);
        endfunction

        // Compares one accepted result beat with the oldest owed result.
        task check_result(t_result got);
            t_result want;
            if (owed.size() == 0) begin
                report($sformatf("result beat with nothing owed: %h", got));
            end else begin
                want = owed.pop_front();
                if (got.read_data !== want.read_data)
                    report($sformatf("read_data %h, want %h", got.read_data, want.read_data));
                if (got.tx_valid !== want.tx_valid)
                    report($sformatf("tx_valid %b, want %b", got.tx_valid, want.tx_valid));
                if (got.tx_byte !== want.tx_byte)
                    report($sformatf("tx_byte %h, want %h", got.tx_byte, want.tx_byte));
                if (got.irq_receive !== want.irq_receive)
                    report($sformatf("irq_receive %b, want %b",
                                     got.irq_receive, want.irq_receive));
                if (got.irq_transmit !== want.irq_transmit)
                    report($sformatf("irq_transmit %b, want %b",
                                     got.irq_transmit, want.irq_transmit));
                if (got.irq_empty !== want.irq_empty)
                    report($sformatf("irq_empty %b, want %b", got.irq_empty, want.irq_empty));
            end
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_opcode;
    logic [1:0] i_reg_select;
    logic [7:0] i_data_byte;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_read_data;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic       o_irq_receive;
    logic       o_irq_transmit;
    logic       o_irq_empty;

    // Idling is enabled in stretches and switched off for the tail of the
    // run. After its initial value it is updated only with nonblocking assignments so that the
    // sender and the stall generator see the same value at a given edge.
    logic idle_on;
    int   stall_left;
    int   cycle_count;
    int   beats_sent;

    uart_flag_scoreboard flags_sb = new();

    uart_rx_fifo_irq_flags_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_reg_select   (i_reg_select),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_read_data    (o_read_data),
        .o_tx_valid     (o_tx_valid),
        .o_tx_byte      (o_tx_byte),
        .o_irq_receive  (o_irq_receive),
        .o_irq_transmit (o_irq_transmit),
        .o_irq_empty    (o_irq_empty)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog. The slowest correct run takes far fewer cycles than this, even
    // with every beat hitting the longest sender gap and receiver stall.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("uart_rx_fifo_irq_flags_top verification failed");
            $finish;
        end
    end

    // Receiver back-pressure: random stall bursts of random length.
    always @(posedge i_clk) begin
        if (!idle_on) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // A result beat is taken at an edge where o_valid is high and our stall is
    // low. All values read here are the ones from before the edge.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.read_data    = o_read_data;
            got.tx_valid     = o_tx_valid;
            got.tx_byte      = o_tx_byte;
            got.irq_receive  = o_irq_receive;
            got.irq_transmit = o_irq_transmit;
            got.irq_empty    = o_irq_empty;
            flags_sb.check_result(got);
        end
    end

    // Presents one input beat, optionally after a random gap, and returns at
    // the edge where the block takes it. The model is updated at that point.
    task automatic drive_beat(logic [1:0] op, logic [1:0] sel, logic [7:0] v);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_reg_select <= sel;
        i_data_byte  <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        flags_sb.note_beat(op, sel, v);
        if (op != OP_UNUSED)
            beats_sent++;
    endtask

    // Holds the sender off until every owed result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (flags_sb.owed.size() != 0) @(posedge i_clk);
    endtask

    // A well-formed receive sequence: enable the receiver with random
    // interrupt enables, push line bytes (sometimes more than the store can
    // hold), mix in a send or a status read, then pop the store with reads.
    task automatic receive_sequence();
        logic [7:0] ctl;
        logic [7:0] gbl;
        ctl = 8'($urandom_range(0, 255));
        ctl[BIT_RXEN] = 1'b1;
        drive_beat(OP_WRITE, REG_CTRL, ctl);
        if ($urandom_range(0, 2) == 0) begin
            gbl = 8'($urandom_range(0, 255));
            drive_beat(OP_WRITE, REG_GLOBAL, gbl);
        end
        repeat ($urandom_range(1, 3))
            drive_beat(OP_LINE, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) == 0)
            drive_beat(OP_WRITE, REG_DATA, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) == 0)
            drive_beat(OP_READ, REG_STATUS, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 4))
            drive_beat(OP_READ, REG_DATA, 8'($urandom_range(0, 255)));
    endtask

    // Any single beat, including the unused opcode. Control writes mostly
    // keep the receiver enabled so that the store does not stay empty.
    task automatic random_beat();
        int         pick;
        logic [1:0] op;
        logic [1:0] sel;
        logic [7:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            op = OP_LINE;
        else if (pick < 60)
            op = OP_READ;
        else if (pick < 96)
            op = OP_WRITE;
        else
            op = OP_UNUSED;
        sel = 2'($urandom_range(0, 3));
        v = 8'($urandom_range(0, 255));
        if (op == OP_WRITE && sel == REG_CTRL && $urandom_range(0, 3) != 0)
            v[BIT_RXEN] = 1'b1;
        drive_beat(op, sel, v);
    endtask

    initial begin
        bit quiet_stretch;
        bit pressure_done;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_opcode     = OP_LINE;
        i_reg_select = REG_DATA;
        i_data_byte  = 8'h00;
        i_stall      = 1'b0;
        idle_on      = 1'b0;
        stall_left   = 0;
        cycle_count  = 0;
        beats_sent   = 0;
        quiet_stretch = 1'b0;
        pressure_done = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: reset values of every register, a line byte with the
        // receiver off, the unused opcode, sends with interrupts globally off,
        // the store filling past its depth, a rising global enable with a
        // receive flag pending, pops of the hold byte and of the last byte, a
        // read of the empty store, and the transmit and data-empty interrupts
        // fired by control writes enabling them while their flags are pending.
        drive_beat(OP_READ, REG_GLOBAL, 8'h00);
        drive_beat(OP_READ, REG_STATUS, 8'hFF);
        drive_beat(OP_READ, REG_CTRL, 8'h00);
        drive_beat(OP_READ, REG_DATA, 8'hFF);
        drive_beat(OP_LINE, REG_DATA, 8'hFF);
        drive_beat(OP_UNUSED, REG_GLOBAL, 8'hFF);
        drive_beat(OP_WRITE, REG_DATA, 8'h00);
        drive_beat(OP_WRITE, REG_STATUS, 8'hFF);
        drive_beat(OP_WRITE, REG_DATA, 8'hFF);
        drive_beat(OP_WRITE, REG_CTRL, 8'h90);
        drive_beat(OP_LINE, REG_STATUS, 8'hA5);
        drive_beat(OP_LINE, REG_CTRL, 8'h5A);
        drive_beat(OP_LINE, REG_GLOBAL, 8'h00);
        drive_beat(OP_WRITE, REG_GLOBAL, 8'h80);
        drive_beat(OP_WRITE, REG_GLOBAL, 8'hFF);
        drive_beat(OP_READ, REG_DATA, 8'h00);
        drive_beat(OP_READ, REG_DATA, 8'h00);
        drive_beat(OP_READ, REG_DATA, 8'h00);
        drive_beat(OP_WRITE, REG_CTRL, 8'hD0);
        drive_beat(OP_WRITE, REG_DATA, 8'h3C);
        drive_beat(OP_WRITE, REG_CTRL, 8'h00);
        drive_beat(OP_WRITE, REG_CTRL, 8'h40);
        drive_beat(OP_WRITE, REG_CTRL, 8'h20);
        drive_beat(OP_WRITE, REG_STATUS, 8'h40);
        drive_beat(OP_WRITE, REG_GLOBAL, 8'h7F);

        // Random part. Idling runs in stretches that switch on and off, with a
        // quiet tail at the end; the sender drains the block once midway.
        while (beats_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 39) == 0)
                quiet_stretch = !quiet_stretch;
            idle_on <= !quiet_stretch && (beats_sent < ITEM_TARGET - QUIET_TAIL);
            if (!pressure_done && beats_sent >= ITEM_TARGET / 2) begin
                drain_results();
                pressure_done = 1'b1;
            end
            if ($urandom_range(0, 9) < 6)
                receive_sequence();
            else
                random_beat();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (flags_sb.owed.size() != 0)
            flags_sb.report($sformatf("result never arrived: %h", flags_sb.owed.pop_front()));
        if (flags_sb.errors == 0)
            $display("uart_rx_fifo_irq_flags_top verification clean");
        else
            $display("uart_rx_fifo_irq_flags_top verification failed");
        $finish;
    end

endmodule
